// ===== rtl/core/bcrt_pkg.sv =====
// ----------------------------------------------------------------------------
// bcrt_pkg
// Shared types, codes and helper functions for the boot capability
// readiness tracker.
// ----------------------------------------------------------------------------
package bcrt_pkg;

    localparam int CAPS       = 14;
    localparam int SEQ_BITS   = 16;
    localparam int REQ_W      = 2 * CAPS;
    localparam int CAP_IDX_W  = $clog2(CAPS);

    // operation codes
    localparam logic [2:0] OP_BEGIN    = 3'd0;
    localparam logic [2:0] OP_RECORD   = 3'd1;
    localparam logic [2:0] OP_COMPLETE = 3'd2;
    localparam logic [2:0] OP_MARK_RUN = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    // requirement codes
    localparam logic [1:0] REQ_DISABLED = 2'd0;
    localparam logic [1:0] REQ_OPTIONAL = 2'd1;

    // outcome codes
    localparam logic [1:0] OUT_READY       = 2'd0;
    localparam logic [1:0] OUT_DEGRADED    = 2'd1;
    localparam logic [1:0] OUT_UNAVAILABLE = 2'd2;
    localparam logic [1:0] OUT_FATAL       = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] phase_id;
        logic [3:0] capability_id;
        logic [1:0] reported_outcome;
    } bcrt_in_t;

    typedef struct packed {
        logic                accepted;
        logic                order_ok;
        logic                in_phase;
        logic                running;
        logic [3:0]          current_phase;
        logic [SEQ_BITS-1:0] step_count;
        logic                may_run;
        logic                any_degraded;
        logic                any_fatal;
        logic [1:0]          overall;
        logic                entry_seen;
        logic [1:0]          entry_result;
    } bcrt_out_t;

    // tracking state snapshot
    typedef struct packed {
        logic [CAPS-1:0][1:0] outcome;
        logic [CAPS-1:0]      seen;
        logic [3:0]           open_phase;
        logic                 phase_open;
        logic                 order_ok;
        logic                 running;
        logic [SEQ_BITS-1:0]  seq;
    } bcrt_track_t;

    // per-item status handed from the update stage to the summary stage
    typedef struct packed {
        logic       valid;
        logic       accepted;
        logic [3:0] capability_id;
    } bcrt_step_t;

    function automatic logic allows_run(input logic [1:0] req, input logic seen,
                                        input logic [1:0] oc);
        logic ok;
        if (req == REQ_DISABLED)
            ok = 1'b1;
        else if (!seen)
            ok = 1'b0;
        else if (req == REQ_OPTIONAL)
            ok = (oc == OUT_READY) || (oc == OUT_DEGRADED);
        else
            ok = (oc == OUT_READY);
        return ok;
    endfunction

    function automatic logic is_fatal(input logic seen, input logic [1:0] oc);
        return seen && (oc == OUT_FATAL);
    endfunction

    function automatic logic is_degraded(input logic [1:0] req, input logic seen,
                                         input logic [1:0] oc);
        return (req == REQ_OPTIONAL) && seen && (oc == OUT_DEGRADED);
    endfunction

endpackage

// ===== rtl/core/bcrt_state.sv =====
// ----------------------------------------------------------------------------
// bcrt_state
// Tracking state and its registered update for each registered operation.
// ----------------------------------------------------------------------------
module bcrt_state (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  bcrt_pkg::bcrt_in_t                in_item,
    input  logic [bcrt_pkg::REQ_W-1:0]        req_codes,
    output bcrt_pkg::bcrt_track_t             track,
    output bcrt_pkg::bcrt_step_t              step
);

    bcrt_pkg::bcrt_track_t track_reg;
    bcrt_pkg::bcrt_track_t track_next;
    bcrt_pkg::bcrt_step_t  step_reg;
    bcrt_pkg::bcrt_step_t  step_next;

    logic                            cap_valid;
    logic [bcrt_pkg::CAP_IDX_W-1:0]  cap_idx;
    logic [1:0]                      cap_req;
    logic                            all_ok;
    logic                            can_run;
    logic                            acc;
    logic [bcrt_pkg::SEQ_BITS-1:0]   seq_inc;

    assign cap_valid = 32'(in_item.capability_id) < bcrt_pkg::CAPS;
    assign cap_idx   = in_item.capability_id[bcrt_pkg::CAP_IDX_W-1:0];
    assign cap_req   = cap_valid ? req_codes[2*cap_idx +: 2] : bcrt_pkg::REQ_DISABLED;
    assign seq_inc   = track_reg.seq + 1'b1;

    always_comb
    begin
        all_ok = 1'b1;
        for (int i = 0; i < bcrt_pkg::CAPS; i++)
        begin
            if (!bcrt_pkg::allows_run(req_codes[2*i +: 2], track_reg.seen[i],
                                      track_reg.outcome[i]))
                all_ok = 1'b0;
        end
    end

    assign can_run = track_reg.order_ok && !track_reg.phase_open &&
                     !track_reg.running && all_ok;

    always_comb
    begin
        track_next = track_reg;
        acc        = 1'b0;
        if (in_valid)
        begin
            case (in_item.operation)
                bcrt_pkg::OP_BEGIN:
                begin
                    track_next.seq = seq_inc;
                    if (track_reg.phase_open || track_reg.running)
                        track_next.order_ok = 1'b0;
                    else
                    begin
                        track_next.open_phase = in_item.phase_id;
                        track_next.phase_open = 1'b1;
                        acc = 1'b1;
                    end
                end
                bcrt_pkg::OP_RECORD:
                begin
                    if (cap_valid)
                    begin
                        track_next.seq = seq_inc;
                        if (!track_reg.phase_open || track_reg.running ||
                            cap_req == bcrt_pkg::REQ_DISABLED)
                            track_next.order_ok = 1'b0;
                        else
                        begin
                            track_next.outcome[cap_idx] = in_item.reported_outcome;
                            track_next.seen[cap_idx]    = 1'b1;
                            acc = 1'b1;
                        end
                    end
                end
                bcrt_pkg::OP_COMPLETE:
                begin
                    track_next.seq = seq_inc;
                    if (!track_reg.phase_open || track_reg.running ||
                        track_reg.open_phase != in_item.phase_id)
                        track_next.order_ok = 1'b0;
                    else
                    begin
                        track_next.phase_open = 1'b0;
                        acc = 1'b1;
                    end
                end
                bcrt_pkg::OP_MARK_RUN:
                begin
                    if (can_run)
                    begin
                        track_next.seq     = seq_inc;
                        track_next.running = 1'b1;
                        acc = 1'b1;
                    end
                end
                bcrt_pkg::OP_CLEAR:
                begin
                    track_next            = '0;
                    track_next.order_ok   = 1'b1;
                    track_next.seq        = seq_inc;
                    acc = 1'b1;
                end
                default:
                begin
                    acc = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        step_next.valid         = in_valid;
        step_next.accepted      = acc;
        step_next.capability_id = in_item.capability_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg          <= '0;
            track_reg.order_ok <= 1'b1;
            step_reg           <= '0;
        end
        else
        begin
            track_reg <= track_next;
            step_reg  <= step_next;
        end
    end

    assign track = track_reg;
    assign step  = step_reg;

`ifndef SYNTHESIS
    // counter moves by one at most per operation
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (track_reg.seq == $past(track_reg.seq)) ||
                 (track_reg.seq == bcrt_pkg::SEQ_BITS'($past(track_reg.seq) + 1'b1)))
        else $error("sequence counter jumped");

    // no operation, no state change
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |=> $stable(track_reg))
        else $error("tracking state changed without an operation");

    // a granted mark-run leaves the block running
    a_run_set: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_item.operation == bcrt_pkg::OP_MARK_RUN && can_run
        |=> track_reg.running && step_reg.accepted)
        else $error("mark run granted but not running");

    // rejected operation never opens a phase
    a_reject_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !acc && !track_reg.phase_open |=> !track_reg.phase_open)
        else $error("rejected operation opened a phase");
`endif

endmodule

// ===== rtl/core/bcrt_summary.sv =====
// ----------------------------------------------------------------------------
// bcrt_summary
// Readiness summaries over all capabilities and the result register.
// ----------------------------------------------------------------------------
module bcrt_summary (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bcrt_pkg::bcrt_track_t             track,
    input  bcrt_pkg::bcrt_step_t              step,
    input  logic [bcrt_pkg::REQ_W-1:0]        req_codes,
    output logic                              done,
    output bcrt_pkg::bcrt_out_t               result
);

    bcrt_pkg::bcrt_out_t             result_reg;
    bcrt_pkg::bcrt_out_t             result_next;
    logic                            done_reg;

    logic                            deg;
    logic                            fat;
    logic                            all_ok;
    logic [1:0]                      scan;
    logic                            cap_valid;
    logic [bcrt_pkg::CAP_IDX_W-1:0]  cap_idx;

    assign cap_valid = 32'(step.capability_id) < bcrt_pkg::CAPS;
    assign cap_idx   = step.capability_id[bcrt_pkg::CAP_IDX_W-1:0];

    // scanned from the top so the lowest failing entry decides
    always_comb
    begin
        deg    = 1'b0;
        fat    = 1'b0;
        all_ok = 1'b1;
        for (int i = 0; i < bcrt_pkg::CAPS; i++)
        begin
            if (bcrt_pkg::is_degraded(req_codes[2*i +: 2], track.seen[i], track.outcome[i]))
                deg = 1'b1;
            if (bcrt_pkg::is_fatal(track.seen[i], track.outcome[i]))
                fat = 1'b1;
            if (!bcrt_pkg::allows_run(req_codes[2*i +: 2], track.seen[i], track.outcome[i]))
                all_ok = 1'b0;
        end
        scan = deg ? bcrt_pkg::OUT_DEGRADED : bcrt_pkg::OUT_READY;
        for (int i = bcrt_pkg::CAPS - 1; i >= 0; i--)
        begin
            if (bcrt_pkg::is_fatal(track.seen[i], track.outcome[i]))
                scan = bcrt_pkg::OUT_FATAL;
            else if (!bcrt_pkg::allows_run(req_codes[2*i +: 2], track.seen[i],
                                           track.outcome[i]))
                scan = bcrt_pkg::OUT_UNAVAILABLE;
        end
    end

    always_comb
    begin
        result_next.accepted      = step.accepted;
        result_next.order_ok      = track.order_ok;
        result_next.in_phase      = track.phase_open;
        result_next.running       = track.running;
        result_next.current_phase = track.open_phase;
        result_next.step_count    = track.seq;
        result_next.may_run       = track.order_ok && !track.phase_open &&
                                    !track.running && all_ok;
        result_next.any_degraded  = deg;
        result_next.any_fatal     = fat;
        result_next.overall       = track.order_ok ? scan : bcrt_pkg::OUT_UNAVAILABLE;
        result_next.entry_seen    = cap_valid ? track.seen[cap_idx] : 1'b0;
        result_next.entry_result  = cap_valid ? track.outcome[cap_idx] : bcrt_pkg::OUT_READY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= step.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/boot_capability_readiness_tracker.sv =====
// ----------------------------------------------------------------------------
// boot_capability_readiness_tracker
// Boot phase and capability outcome tracker with an apb requirement register.
// ----------------------------------------------------------------------------

// One operation is taken on every clock at which start is high; busy never
// rises, so a new operation may follow in the very next cycle. Each operation
// yields exactly one result, shown on result with done high for a single
// cycle, after passing the input register, state update and summary
// register. The receiver cannot stall, so results must be captured
// when done is high. Throughput is one operation per clock, set by the state
// update stage, which reads and rewrites the tracking state.
// The requirement codes live at byte address 0 of the apb port and should
// only be written while no operation is in flight.
module boot_capability_readiness_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    // operation channel
    input  logic                 start,
    output logic                 busy,
    input  bcrt_pkg::bcrt_in_t   item,
    // result channel
    output logic                 done,
    output bcrt_pkg::bcrt_out_t  result,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // requirement register, two bits per capability
    logic [bcrt_pkg::REQ_W-1:0] req_reg;
    logic                       cfg_write;
    logic                       reg_sel;

    // input register
    logic                       valid_reg;
    bcrt_pkg::bcrt_in_t         item_reg;

    bcrt_pkg::bcrt_track_t      track;
    bcrt_pkg::bcrt_step_t       step;

    // every cycle can take a transfer
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // word decode, byte lanes ignored
    assign reg_sel   = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite && reg_sel;
    assign prdata    = reg_sel ? 32'(req_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_reg <= '0;
        else if (cfg_write)
            req_reg <= pwdata[bcrt_pkg::REQ_W-1:0];
    end

    // capture the operation, valid flag resets, payload does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item;
    end

    // state update stage
    bcrt_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg),
        .in_item   (item_reg),
        .req_codes (req_reg),
        .track     (track),
        .step      (step)
    );

    // summaries and result register
    bcrt_summary u_summary (
        .clk       (clk),
        .rst_n     (rst_n),
        .track     (track),
        .step      (step),
        .req_codes (req_reg),
        .done      (done),
        .result    (result)
    );

`ifndef SYNTHESIS
    // every accepted operation produces its result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("operation transfer without a result");
`endif

endmodule
